// ----- sv/kse_pkg.sv -----
// Package for the keyed stack engine.
// Holds the transaction structs, operation and status codes, and the control structs.
// Has no dependencies.
`default_nettype none

package kse_pkg;

    localparam int DEPTH = 16;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] operand_value;
        logic signed [31:0] new_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [CW-1:0]      entry_count;
        logic signed [31:0] top_value;
        logic               top_valid;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/kse_ctrl.sv -----
// Controller state machine of the keyed stack engine.
// Sequences capture and execute commands for the datapath; depends on kse_pkg.
`default_nettype none

module kse_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  kse_pkg::t_dp_status  i_status,
    output kse_pkg::t_ctl_cmd    o_cmd
);
    import kse_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_status.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- sv/kse_datapath.sv -----
// Datapath of the keyed stack engine: entry cells, parallel key match and result register.
// Driven by commands from kse_ctrl; depends on kse_pkg.
`default_nettype none

module kse_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  kse_pkg::t_ctl_cmd    i_cmd,
    output kse_pkg::t_dp_status  o_status,
    input  kse_pkg::t_in_item    i_in,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output kse_pkg::t_out_item   o_out
);
    import kse_pkg::*;

    logic [31:0]    r_entries [DEPTH];
    logic [31:0]    n_entries [DEPTH];
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [DEPTH-1:0] r_match;
    logic [DEPTH-1:0] n_match;
    t_in_item       r_item;
    logic           r_out_valid;
    t_out_item      r_out;

    logic           found;
    logic [IW-1:0]  pos;
    logic [IW-1:0]  ins_idx;
    logic [CW-1:0]  top_sum;
    logic [IW-1:0]  top_idx;
    logic [1:0]     n_st;
    logic           full;
    logic           empty;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_match[i] = (r_entries[i] == i_in.operand_value) && (i < int'(r_count));
        end
    end

    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_match[i]) begin
                pos = IW'(i);
            end
        end
    end

    assign found   = |r_match;
    assign ins_idx = pos + 1'b1;
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_st      = ST_OK;
        case (r_item.operation)
            OP_PUSH: begin
                if (full) begin
                    n_st = ST_FULL;
                end else begin
                    n_entries[r_count[IW-1:0]] = r_item.operand_value;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP: begin
                if (empty) begin
                    n_st = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_DELETE: begin
                if (!found) begin
                    n_st = ST_MISSING;
                end else begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (i >= int'(pos) && i + 1 < int'(r_count)) begin
                            n_entries[i] = r_entries[i + 1];
                        end
                    end
                    n_count = r_count - 1'b1;
                end
            end
            OP_INSERT: begin
                if (full) begin
                    n_st = ST_FULL;
                end else if (!found) begin
                    n_st = ST_MISSING;
                end else begin
                    for (int i = 1; i < DEPTH; i++) begin
                        if (i > int'(pos) + 1 && i <= int'(r_count)) begin
                            n_entries[i] = r_entries[i - 1];
                        end
                    end
                    n_entries[ins_idx] = r_item.new_value;
                    n_count = r_count + 1'b1;
                end
            end
            OP_UPDATE: begin
                if (!found) begin
                    n_st = ST_MISSING;
                end else begin
                    n_entries[pos] = r_item.new_value;
                end
            end
            default: begin
                n_st = ST_OK;
            end
        endcase
    end

    assign top_sum = n_count - 1'b1;
    assign top_idx = top_sum[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item  <= i_in;
            r_match <= n_match;
        end
        if (i_cmd.exec) begin
            r_entries             <= n_entries;
            r_out.status          <= n_st;
            r_out.entry_count     <= n_count;
            r_out.top_valid       <= (n_count != '0);
            r_out.top_value       <= (n_count != '0) ? n_entries[top_idx] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule

`default_nettype wire

// ----- sv/keyed_stack_engine.sv -----
// Keyed stack engine: a bounded stack of 16 signed 32-bit entries with key search.
// Each input transaction carries push, pop, delete by key, insert after key or update.
// Each input transaction yields exactly one output transaction with status, entry
// count and the top value after the operation.
// Both channels use valid and stall; a transaction moves on a clock edge with valid
// high and stall low.
// An accepted transaction has its parallel key match over the occupied cells registered at the
// accepting edge and executes once the result register is free; no new transaction is
// taken until it has executed. The result is held in the result register from execution
// until the receiver takes it.
// The result register holds its transaction while the receiver stalls; the next input
// transaction is still accepted and matched, and execution waits for the register.
// Reset empties the stack and clears the output valid; entry contents are not cleared.
// Depends on kse_pkg, kse_ctrl and kse_datapath.
`default_nettype none

module keyed_stack_engine (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  kse_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output kse_pkg::t_out_item  o_out
);
    import kse_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    kse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kse_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.entry_count <= CW'(DEPTH)))
        else $error("entry count exceeds depth");

    a_top_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.top_valid == (o_out.entry_count != '0)))
        else $error("top valid disagrees with entry count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_FULL) |-> (o_out.entry_count == CW'(DEPTH)))
        else $error("full status with room left");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a transaction is in progress");
`endif

endmodule

`default_nettype wire
